// ===== src/register_mapped_divider_unit_defines.svh =====
// Assertion macros shared by the divider unit RTL.
`ifndef REGISTER_MAPPED_DIVIDER_UNIT_DEFINES_SVH
`define REGISTER_MAPPED_DIVIDER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RMDU_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RMDU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/rmdu_pkg.sv =====
// Types, constants and helper functions of the register mapped divider unit.
`default_nettype none
package rmdu_pkg;

   localparam int DATA_W  = 32;
   localparam int COUNT_W = $clog2(DATA_W);
   localparam int OFF_W   = 5;
   localparam int SIZE_W  = 2;
   localparam int IDX_W   = 3;
   localparam int NUM_REGS = 6;

   localparam logic [COUNT_W-1:0] LAST_STEP = COUNT_W'(DATA_W - 1);

   // Register indexes, i.e. the word offset inside the window.
   localparam logic [IDX_W-1:0] IDX_UDIVIDEND = 3'd0;
   localparam logic [IDX_W-1:0] IDX_UDIVISOR  = 3'd1;
   localparam logic [IDX_W-1:0] IDX_SDIVIDEND = 3'd2;
   localparam logic [IDX_W-1:0] IDX_SDIVISOR  = 3'd3;
   localparam logic [IDX_W-1:0] IDX_QUOTIENT  = 3'd4;
   localparam logic [IDX_W-1:0] IDX_REMAINDER = 3'd5;
   localparam logic [IDX_W-1:0] IDX_CONTROL   = 3'd6;

   localparam int CTRL_DIRTY_BIT = 1;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd0;
   localparam logic [SIZE_W-1:0] SIZE_HALF = 2'd1;

   typedef enum logic [1:0] {
      RMDU_IDLE,
      RMDU_DIVIDE,
      RMDU_FINISH
   } rmdu_state_type;

   function automatic logic [DATA_W-1:0] size_mask(input logic [SIZE_W-1:0] size);
      logic [DATA_W-1:0] mask;
      mask = '1;
      if (size == SIZE_BYTE) begin
         mask = DATA_W'(32'h0000_00FF);
      end else if (size == SIZE_HALF) begin
         mask = DATA_W'(32'h0000_FFFF);
      end
      return mask;
   endfunction

   function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] value);
      return value[DATA_W-1] ? (DATA_W'(0) - value) : value;
   endfunction

endpackage
`default_nettype wire

// ===== src/rmdu_if.sv =====
// Valid/ready channel interfaces for bus accesses and their read responses.
`default_nettype none
interface rmdu_req_if;
   logic                             valid;
   logic                             ready;
   logic                             op;
   logic [rmdu_pkg::OFF_W-1:0]       byte_offset;
   logic [rmdu_pkg::DATA_W-1:0]      write_data;
   logic [rmdu_pkg::SIZE_W-1:0]      access_size;

   modport source (output valid, output op, output byte_offset, output write_data,
                   output access_size, input ready);
   modport sink   (input valid, input op, input byte_offset, input write_data,
                   input access_size, output ready);
endinterface

interface rmdu_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rmdu_pkg::DATA_W-1:0] read_data;

   modport source (output valid, output read_data, input ready);
   modport sink   (input valid, input read_data, output ready);
endinterface
`default_nettype wire

// ===== src/register_mapped_divider_unit.sv =====
// Bus-mapped 32-bit integer divider with unsigned and signed divisor registers.
// Each request word is one access to the divider window and yields exactly one
// response word, posted in the cycle after the request is accepted (writes
// respond with zero). A write of a nonzero divisor starts a restoring division:
// one load, 32 quotient-bit steps through a single 34-bit subtract-and-compare
// unit, and a sign fix-up step that stores quotient and remainder; the unit
// holds off the next request until the fix-up is done. A zero divisor starts
// nothing and leaves the results untouched. The most negative dividend divided
// by minus one yields quotient 0x80000000 and remainder zero. A request is
// taken while the previous response is still pending only if that response
// leaves this cycle.
`default_nettype none
`include "register_mapped_divider_unit_defines.svh"
module register_mapped_divider_unit (
   input wire logic clock,
   input wire logic reset,
   rmdu_req_if.sink   req_bus,
   rmdu_rsp_if.source rsp_bus
);

   rmdu_pkg::rmdu_state_type state_ff, state_in;

   logic [rmdu_pkg::DATA_W-1:0] data_ff [rmdu_pkg::NUM_REGS];
   logic [rmdu_pkg::DATA_W-1:0] data_in [rmdu_pkg::NUM_REGS];
   logic                        dirty_ff, dirty_in;

   logic [rmdu_pkg::DATA_W-1:0]  rem_ff, rem_in;
   logic [rmdu_pkg::DATA_W-1:0]  quo_ff, quo_in;
   logic [rmdu_pkg::DATA_W-1:0]  dsor_ff, dsor_in;
   logic                         neg_q_ff, neg_q_in;
   logic                         neg_r_ff, neg_r_in;
   logic [rmdu_pkg::COUNT_W-1:0] count_ff, count_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [rmdu_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                          accept;
   logic                          aligned;
   logic [rmdu_pkg::IDX_W-1:0]    reg_idx;
   logic [rmdu_pkg::DATA_W-1:0]   read_value;
   logic [rmdu_pkg::DATA_W-1:0]   dividend;
   logic [rmdu_pkg::DATA_W+1:0]   trial;
   logic                          start;
   logic                          busy;
   logic                          last_step;
   logic                          divisor_write;

   assign busy          = (state_ff != rmdu_pkg::RMDU_IDLE);
   assign last_step     = (state_ff == rmdu_pkg::RMDU_DIVIDE) &&
                          (count_ff == rmdu_pkg::LAST_STEP);
   assign req_bus.ready = !busy && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;
   assign aligned       = (req_bus.byte_offset[1:0] == 2'b00);
   assign reg_idx       = req_bus.byte_offset[rmdu_pkg::OFF_W-1:2];
   assign divisor_write = accept && (req_bus.op == rmdu_pkg::OP_WRITE) && aligned &&
                          (reg_idx == rmdu_pkg::IDX_UDIVISOR ||
                           reg_idx == rmdu_pkg::IDX_SDIVISOR) &&
                          (req_bus.write_data != '0);

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.read_data = rsp_data_ff;

   // One restoring step: shift the next dividend bit in and try the subtract.
   assign trial = {1'b0, rem_ff, quo_ff[rmdu_pkg::DATA_W-1]} - {2'b00, dsor_ff};

   always_comb begin
      read_value = '0;
      unique case (reg_idx)
         rmdu_pkg::IDX_UDIVIDEND: read_value = data_ff[rmdu_pkg::IDX_UDIVIDEND];
         rmdu_pkg::IDX_UDIVISOR:  read_value = data_ff[rmdu_pkg::IDX_UDIVISOR];
         rmdu_pkg::IDX_SDIVIDEND: read_value = data_ff[rmdu_pkg::IDX_SDIVIDEND];
         rmdu_pkg::IDX_SDIVISOR:  read_value = data_ff[rmdu_pkg::IDX_SDIVISOR];
         rmdu_pkg::IDX_QUOTIENT:  read_value = data_ff[rmdu_pkg::IDX_QUOTIENT];
         rmdu_pkg::IDX_REMAINDER: read_value = data_ff[rmdu_pkg::IDX_REMAINDER];
         rmdu_pkg::IDX_CONTROL:   read_value[rmdu_pkg::CTRL_DIRTY_BIT] = dirty_ff;
         default:                 read_value = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      data_in      = data_ff;
      dirty_in     = dirty_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dsor_in      = dsor_ff;
      neg_q_in     = neg_q_ff;
      neg_r_in     = neg_r_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      dividend     = '0;
      start        = 1'b0;

      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         rmdu_pkg::RMDU_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               if (req_bus.op == rmdu_pkg::OP_READ) begin
                  if (aligned) begin
                     rsp_data_in = read_value & rmdu_pkg::size_mask(req_bus.access_size);
                     if (reg_idx == rmdu_pkg::IDX_QUOTIENT) begin
                        dirty_in = 1'b0;
                     end
                  end
               end else if (aligned && reg_idx <= rmdu_pkg::IDX_REMAINDER) begin
                  data_in[reg_idx] = req_bus.write_data;
                  dirty_in         = 1'b1;
                  if (reg_idx == rmdu_pkg::IDX_UDIVISOR) begin
                     dividend = data_ff[rmdu_pkg::IDX_UDIVIDEND];
                     dsor_in  = req_bus.write_data;
                     neg_q_in = 1'b0;
                     neg_r_in = 1'b0;
                     start    = (req_bus.write_data != '0);
                  end else if (reg_idx == rmdu_pkg::IDX_SDIVISOR) begin
                     dividend = rmdu_pkg::magnitude(data_ff[rmdu_pkg::IDX_SDIVIDEND]);
                     dsor_in  = rmdu_pkg::magnitude(req_bus.write_data);
                     neg_q_in = data_ff[rmdu_pkg::IDX_SDIVIDEND][rmdu_pkg::DATA_W-1] ^
                                req_bus.write_data[rmdu_pkg::DATA_W-1];
                     neg_r_in = data_ff[rmdu_pkg::IDX_SDIVIDEND][rmdu_pkg::DATA_W-1];
                     start    = (req_bus.write_data != '0);
                  end
                  if (start) begin
                     quo_in   = dividend;
                     rem_in   = '0;
                     count_in = '0;
                     state_in = rmdu_pkg::RMDU_DIVIDE;
                  end
               end
            end
         end
         rmdu_pkg::RMDU_DIVIDE: begin
            if (trial[rmdu_pkg::DATA_W+1]) begin
               rem_in = {rem_ff[rmdu_pkg::DATA_W-2:0], quo_ff[rmdu_pkg::DATA_W-1]};
               quo_in = {quo_ff[rmdu_pkg::DATA_W-2:0], 1'b0};
            end else begin
               rem_in = trial[rmdu_pkg::DATA_W-1:0];
               quo_in = {quo_ff[rmdu_pkg::DATA_W-2:0], 1'b1};
            end
            count_in = count_ff + 1'b1;
            if (count_ff == rmdu_pkg::LAST_STEP) begin
               state_in = rmdu_pkg::RMDU_FINISH;
            end
         end
         rmdu_pkg::RMDU_FINISH: begin
            data_in[rmdu_pkg::IDX_QUOTIENT]  = neg_q_ff ? ('0 - quo_ff) : quo_ff;
            data_in[rmdu_pkg::IDX_REMAINDER] = neg_r_ff ? ('0 - rem_ff) : rem_ff;
            state_in = rmdu_pkg::RMDU_IDLE;
         end
         default: state_in = rmdu_pkg::RMDU_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmdu_pkg::RMDU_IDLE;
         dirty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         for (int i = 0; i < rmdu_pkg::NUM_REGS; i++) begin
            data_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         data_ff      <= data_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dsor_ff     <= dsor_in;
      neg_q_ff    <= neg_q_in;
      neg_r_ff    <= neg_r_in;
      rsp_data_ff <= rsp_data_in;
   end

   `RMDU_ASSERT_NOW(busy_not_ready, busy, !req_bus.ready, "request taken while dividing")
   `RMDU_ASSERT_NEXT(accept_posts_rsp, accept, rsp_valid_ff, "accepted word got no response")
   `RMDU_ASSERT_NEXT(last_step_finishes, last_step, state_ff == rmdu_pkg::RMDU_FINISH, "no finish")
   `RMDU_ASSERT_NEXT(divide_keeps_dirty, busy, dirty_ff, "dirty flag dropped during a division")
   `RMDU_ASSERT_NEXT(nonzero_div_starts, divisor_write, state_ff == rmdu_pkg::RMDU_DIVIDE && count_ff == '0, "no start")

endmodule
`default_nettype wire
